>>> rtl/lis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_pkg - shared types and constants for the tails search
// Default sizes, beat field widths, search state encoding and the result
// record handed from the search engine to the output stage.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned MaxTailsDef  = 1024;
  localparam int unsigned ValueBitsDef = 32;

  // fixed beat field widths
  localparam int unsigned InValueW  = 32;
  localparam int unsigned LenOutW   = 11;
  localparam int unsigned OutTdataW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } srch_state_e;

  typedef struct packed {
    logic               eos;
    logic               overflow;
    logic [LenOutW-1:0] lis_length;
  } lis_res_t;

endpackage

>>> rtl/lis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_ram - generic single-port synchronous RAM
// One access per cycle at one address, write and/or read; read data registered.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lis_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_search - lower-bound search and update of the tails memory
// Binary-searches the sorted tails for the first entry not less than the
// value, one memory read per step, then overwrites that tail or appends one (an append is dropped when full).
// ----------------------------------------------------------------------------
module lis_search #(
  parameter int unsigned MaxTails  = lis_pkg::MaxTailsDef,
  parameter int unsigned ValueBits = lis_pkg::ValueBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ValueBits-1:0]        in_value_i,
  input  logic                        in_last_i,
  output logic                        ram_we_o,
  output logic                        ram_re_o,
  output logic [$clog2(MaxTails)-1:0] ram_addr_o,
  output logic [ValueBits-1:0]        ram_wdata_o,
  input  logic [ValueBits-1:0]        ram_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output lis_pkg::lis_res_t           res_o
);

  localparam int unsigned AW = $clog2(MaxTails);
  localparam int unsigned LW = $clog2(MaxTails + 1);

  lis_pkg::srch_state_e state_q, state_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic                 last_q, last_d;
  logic [LW-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [LW-1:0]        len_q, len_d;
  logic                 ovf_q, ovf_d;

  logic                 less;
  logic [LW-1:0]        lo_n, hi_n, mid_n;
  logic                 append, full;
  logic [LW-1:0]        len_new;
  logic                 ovf_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lis_pkg::ST_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
  end

  // one search step: compare the tail read last cycle, narrow the range
  assign less  = $signed(ram_rdata_i) < $signed(val_q);
  assign lo_n  = less ? mid_q + LW'(1) : lo_q;
  assign hi_n  = less ? hi_q : mid_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

  // lo equals len when every tail is smaller
  assign append  = (lo_q == len_q);
  assign full    = (len_q == LW'(MaxTails));
  assign len_new = (append && !full) ? len_q + LW'(1) : len_q;
  assign ovf_new = ovf_q | (append && full);

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = mid_q[AW-1:0];
    ram_wdata_o = val_q;
    res_valid_o = 1'b0;
    res_o.lis_length = lis_pkg::LenOutW'(len_new);
    res_o.overflow   = ovf_new;
    res_o.eos        = last_q;

    unique case (state_q)
      lis_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d  = in_value_i;
          last_d = in_last_i;
          lo_d   = '0;
          hi_d   = len_q;
          mid_d  = len_q >> 1;
          if (len_q != '0) begin
            ram_re_o   = 1'b1;
            ram_addr_o = mid_d[AW-1:0];
            state_d    = lis_pkg::ST_SEARCH;
          end else begin
            state_d = lis_pkg::ST_UPDATE;
          end
        end
      end
      lis_pkg::ST_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d      = mid_n;
          ram_re_o   = 1'b1;
          ram_addr_o = mid_n[AW-1:0];
        end else begin
          state_d = lis_pkg::ST_UPDATE;
        end
      end
      lis_pkg::ST_UPDATE: begin
        res_valid_o = 1'b1;
        ram_addr_o  = lo_q[AW-1:0];
        if (res_ready_i) begin
          // a dropped append leaves the memory alone
          ram_we_o = !(append && full);
          len_d    = last_q ? '0 : len_new;
          ovf_d    = last_q ? 1'b0 : ovf_new;
          state_d  = lis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lis_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/lis_length_tails_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_length_tails_search - running longest strictly increasing subsequence
// Keeps the patience tails in one RAM, binary-searches the lower bound for
// each value and returns the running length with an overflow flag.
// ----------------------------------------------------------------------------
//
// channel   dir  tdata (lsb up)                         tlast
// s_axis    in   value[31:0]                            last item of sequence
// m_axis    out  lis_length[10:0], overflow[11], 0 pad   end of sequence
//
// an item takes an accept step, one RAM read per search step and an update
// step; with an empty tails memory it goes straight from accept to update
// the single RAM port paces the search: each step waits on its read data
// reset clears the length and overflow; the tails RAM needs no clearing
// the next beat is taken while a result waits in the output register; the
// update cycle holds only while that register is full and not being drained
//
module lis_length_tails_search #(
  parameter int unsigned MaxTails  = lis_pkg::MaxTailsDef,
  parameter int unsigned ValueBits = lis_pkg::ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [lis_pkg::InValueW-1:0]  s_axis_tdata_i,   // value
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [lis_pkg::OutTdataW-1:0] m_axis_tdata_o,   // lis_length, overflow
  output logic                          m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(MaxTails);

  logic [ValueBits-1:0] value;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [ValueBits-1:0] ram_wdata, ram_rdata;
  logic                 res_valid, res_ready;
  lis_pkg::lis_res_t    res;
  logic                 out_valid_q;
  lis_pkg::lis_res_t    out_q;

  // value is signed: narrow to the stored width or sign-extend
  if (ValueBits <= lis_pkg::InValueW) begin : g_narrow
    assign value = s_axis_tdata_i[ValueBits-1:0];
  end else begin : g_wide
    assign value = {{(ValueBits - lis_pkg::InValueW){s_axis_tdata_i[lis_pkg::InValueW-1]}},
                    s_axis_tdata_i};
  end

  lis_ram #(
    .Width (ValueBits),
    .Depth (MaxTails)
  ) u_tails (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  lis_search #(
    .MaxTails  (MaxTails),
    .ValueBits (ValueBits)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (value),
    .in_last_i   (s_axis_tlast_i),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(lis_pkg::OutTdataW - lis_pkg::LenOutW - 1){1'b0}},
                            out_q.overflow, out_q.lis_length};
  assign m_axis_tlast_o  = out_q.eos;

  // the search takes one item at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("beat accepted while a search is running");

  // tails are written only when the result is handed on
  a_write_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (res_valid && res_ready && !ram_re))
    else $error("tails write outside the update step");

  // overflow only ever shows with a saturated length
  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[lis_pkg::LenOutW]) |->
      (m_axis_tdata_o[lis_pkg::LenOutW-1:0] == lis_pkg::LenOutW'(MaxTails)))
    else $error("overflow flagged below full length");

  // a running length of zero is never reported while MaxTails fits the length field
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && MaxTails < (1 << lis_pkg::LenOutW)) |-> (res.lis_length != '0))
    else $error("zero length result");

endmodule
